// ===== hdl/nma_pkg.sv =====
// shared constants, codes and types for the nearest marked ancestor engine
`default_nettype none
package nma_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = 10;
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int SUM_W  = 48;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NEW   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_WALK  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WALK  = 3'b100
  } nma_state_t;

  typedef struct packed {
    logic              par_we;
    logic              mark_we;
    logic              mark_wd;
    logic [NODE_W-1:0] wr_addr;
    logic [NODE_W-1:0] par_wd;
    logic [NODE_W-1:0] rd_addr;
  } nma_mem_req_t;

endpackage
`default_nettype wire

// ===== hdl/nma_store.sv =====
// parent table and mark bits, one write and one registered read per cycle
`default_nettype none
module nma_store (
  input  wire logic                       clk,
  input  wire nma_pkg::nma_mem_req_t      req,
  output logic [nma_pkg::NODE_W-1:0]      rd_par,
  output logic                            rd_mark
);
  import nma_pkg::*;

  logic [NODE_W-1:0] par_mem [NODES];
  logic              mark_mem [NODES];

  always_ff @(posedge clk) begin
    if (req.par_we) begin
      par_mem[req.wr_addr] <= req.par_wd;
    end
    rd_par <= par_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.mark_we) begin
      mark_mem[req.wr_addr] <= req.mark_wd;
    end
    rd_mark <= mark_mem[req.rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/nearest_marked_ancestor_core.sv =====
// nearest marked ancestor engine: command decode, parent walk and running total
//
//   channel   ports                                        handshake
//   request   in_cmd, in_node, in_parent_node              start & !busy
//   result    out_ancestor, out_query_sum, out_status      out_valid, one cycle
//   config    cfg_node_count                               cfg_wr_en
//
// load, mark and rejected queries: result in the cycle after the request.
// query: the walk takes one step per node visited, the start node included (one read of
// the parent table per step), result the cycle after the walk ends.
// a looping walk visits node count + 1 nodes before it is flagged.
// new case: result next cycle, then the mark bits are cleared.
// after reset the same mark clearing runs with busy high.
// the receiver cannot stall; each result is shown for a single cycle.
`default_nettype none
module nearest_marked_ancestor_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [nma_pkg::NODE_W-1:0]    in_node,
  input  wire logic [nma_pkg::NODE_W-1:0]    in_parent_node,
  output logic                               out_valid,
  output logic [nma_pkg::NODE_W-1:0]         out_ancestor,
  output logic [nma_pkg::SUM_W-1:0]          out_query_sum,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [nma_pkg::CNT_W-1:0]     cfg_node_count
);
  import nma_pkg::*;

  nma_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  node_count_r;
  logic [CNT_W-1:0]  lim;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_anc_r, out_anc_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  nma_mem_req_t      mem_req;
  logic [NODE_W-1:0] rd_par;
  logic              rd_mark;

  nma_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_par  (rd_par),
    .rd_mark (rd_mark)
  );

  // node count clamped to 1..NODES
  always_comb begin
    if (node_count_r == '0) begin
      lim = CNT_W'(1);
    end else if (node_count_r > CNT_W'(NODES)) begin
      lim = CNT_W'(NODES);
    end else begin
      lim = node_count_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    clr_nxt        = clr_r;
    total_nxt      = total_r;
    out_valid_nxt  = 1'b0;
    out_anc_nxt    = '0;
    out_status_nxt = out_status_r;
    mem_req        = '0;
    mem_req.rd_addr = cur_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.mark_we = 1'b1;
        mem_req.mark_wd = 1'b0;
        mem_req.wr_addr = clr_r;
        if (clr_r == NODE_W'(NODES - 1)) begin
          state_nxt = ST_IDLE;
          clr_nxt   = '0;
        end else begin
          clr_nxt = clr_r + NODE_W'(1);
        end
      end
      ST_IDLE: begin
        mem_req.rd_addr = in_node;
        if (start) begin
          case (in_cmd)
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              if (CNT_W'(in_node) >= lim || CNT_W'(in_parent_node) >= lim) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                out_status_nxt  = STAT_OK;
                mem_req.par_we  = 1'b1;
                mem_req.wr_addr = in_node;
                mem_req.par_wd  = in_parent_node;
              end
            end
            CMD_MARK: begin
              out_valid_nxt = 1'b1;
              if (CNT_W'(in_node) >= lim) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                out_status_nxt  = STAT_OK;
                mem_req.mark_we = 1'b1;
                mem_req.mark_wd = 1'b1;
                mem_req.wr_addr = in_node;
              end
            end
            CMD_QUERY: begin
              if (CNT_W'(in_node) >= lim) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_RANGE;
              end else begin
                state_nxt = ST_WALK;
                cur_nxt   = in_node;
                steps_nxt = '0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
              total_nxt      = '0;
              state_nxt      = ST_CLEAR;
              clr_nxt        = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        // next link read straight from the returned parent
        mem_req.rd_addr = rd_par;
        if (cur_r == '0 || rd_mark || rd_par == cur_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_anc_nxt    = cur_r;
          total_nxt      = total_r + SUM_W'(cur_r) + SUM_W'(1);
          state_nxt      = ST_IDLE;
        end else if (steps_r >= lim) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_WALK;
          state_nxt      = ST_IDLE;
        end else if (CNT_W'(rd_par) >= lim) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_RANGE;
          state_nxt      = ST_IDLE;
        end else begin
          cur_nxt   = rd_par;
          steps_nxt = steps_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      node_count_r <= CNT_W'(NODES);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    out_anc_r    <= out_anc_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ancestor  = out_anc_r;
  assign out_query_sum = total_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> steps_r <= lim)
    else $error("walk step count beyond node count");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != CMD_QUERY) |=> out_valid)
    else $error("no result after non-query request");

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> out_ancestor == '0)
    else $error("flagged result with non-zero ancestor");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_RANGE
                   || out_status == STAT_WALK))
    else $error("undefined status code");

  a_new_case_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_NEW) |=> out_query_sum == '0)
    else $error("total not cleared by new case");
`endif

endmodule
`default_nettype wire
